/* rtl/frag_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and helper function for the frame rotation
// address generator. No dependencies.
package frag_pkg;

  localparam int MAX_SIDE = 512;
  localparam int CNT_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = CNT_W + 1;
  localparam int DIM_W    = 10;
  localparam int EXT_W    = (SIDE_W > DIM_W) ? SIDE_W : DIM_W;
  localparam int ADDR_W   = 18;
  localparam int PIX_W    = 16;
  localparam int PROD_W   = (CNT_W + SIDE_W > ADDR_W) ? CNT_W + SIDE_W : ADDR_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIM_W;

  localparam int IN_TDATA_W  = ((PIX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((ADDR_W + PIX_W + 7) / 8) * 8;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = DIM_W'(480);
  localparam logic [DIM_W-1:0] HEIGHT_RESET = DIM_W'(320);

  typedef enum logic [1:0] {
    ROT_0   = 2'd0,
    ROT_90  = 2'd1,
    ROT_180 = 2'd2,
    ROT_270 = 2'd3
  } rot_t;

  localparam logic [CFG_IDX_W-1:0] CFG_ROTATION = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = CFG_IDX_W'(2);

  typedef struct packed {
    rot_t              rotation;
    logic [SIDE_W-1:0] side_w;
    logic [SIDE_W-1:0] side_h;
    logic              restart;
  } cfg_view_t;

  typedef struct packed {
    logic [CNT_W-1:0]  mul_a;
    logic [SIDE_W-1:0] mul_b;
    logic [CNT_W-1:0]  offset;
    logic [PIX_W-1:0]  pixel;
    logic              frame_end;
  } s1_t;

  // A zero dimension counts as one, an oversized one as the largest side.
  function automatic logic [SIDE_W-1:0] eff_side(input logic [DIM_W-1:0] v);
    logic [EXT_W-1:0] ve;
    ve = EXT_W'(v);
    if (v == '0) begin
      return SIDE_W'(1);
    end else if (ve > EXT_W'(MAX_SIDE)) begin
      return SIDE_W'(MAX_SIDE);
    end else begin
      return SIDE_W'(ve);
    end
  endfunction

endpackage

/* rtl/frag_cfg.sv */
`timescale 1ns / 1ps
// Configuration registers: rotation and frame dimensions, with the
// effective sides derived for the datapath. Depends on frag_pkg.
module frag_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic [frag_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frag_pkg::CFG_DATA_W-1:0] cfg_data,
  output frag_pkg::cfg_view_t            view
);
  import frag_pkg::*;

  rot_t             rotation_r, rotation_nxt;
  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic             restart;

  always_comb begin
    rotation_nxt = rotation_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    restart      = 1'b0;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_ROTATION: rotation_nxt = rot_t'(cfg_data[1:0]);
        CFG_WIDTH: begin
          width_nxt = cfg_data[DIM_W-1:0];
          restart   = 1'b1;
        end
        CFG_HEIGHT: begin
          height_nxt = cfg_data[DIM_W-1:0];
          restart    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= ROT_90;
      width_r    <= WIDTH_RESET;
      height_r   <= HEIGHT_RESET;
    end else begin
      rotation_r <= rotation_nxt;
      width_r    <= width_nxt;
      height_r   <= height_nxt;
    end
  end

  assign view.rotation = rotation_r;
  assign view.side_w   = eff_side(width_r);
  assign view.side_h   = eff_side(height_r);
  assign view.restart  = restart;

endmodule

/* rtl/frag_front.sv */
`timescale 1ns / 1ps
// Column and row counters plus operand selection; loads the stage-one
// register with the multiply-add operands of each pixel. Depends on frag_pkg.
module frag_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  frag_pkg::cfg_view_t        view,
  input  logic                       load,
  input  logic                       take,
  input  logic [frag_pkg::PIX_W-1:0] pixel_in,
  output logic                       s1_valid,
  output frag_pkg::s1_t              s1
);
  import frag_pkg::*;

  logic [CNT_W-1:0]  col_r, col_nxt;
  logic [CNT_W-1:0]  row_r, row_nxt;
  logic              s1_valid_r, s1_valid_nxt;
  s1_t               s1_r, s1_nxt;
  logic [SIDE_W-1:0] col_ext, row_ext, w_last, h_last;
  logic [CNT_W-1:0]  col_flip, row_flip;
  logic              last_col, last_row;

  always_comb begin
    col_ext  = SIDE_W'(col_r);
    row_ext  = SIDE_W'(row_r);
    w_last   = view.side_w - SIDE_W'(1);
    h_last   = view.side_h - SIDE_W'(1);
    col_flip = CNT_W'(w_last - col_ext);
    row_flip = CNT_W'(h_last - row_ext);
    last_col = (col_ext == w_last);
    last_row = (row_ext == h_last);
  end

  always_comb begin
    s1_nxt.pixel     = pixel_in;
    s1_nxt.frame_end = last_col && last_row;
    case (view.rotation)
      ROT_0: begin
        s1_nxt.mul_a  = row_r;
        s1_nxt.mul_b  = view.side_w;
        s1_nxt.offset = col_r;
      end
      ROT_90: begin
        s1_nxt.mul_a  = col_r;
        s1_nxt.mul_b  = view.side_h;
        s1_nxt.offset = row_flip;
      end
      ROT_180: begin
        s1_nxt.mul_a  = row_flip;
        s1_nxt.mul_b  = view.side_w;
        s1_nxt.offset = col_flip;
      end
      default: begin
        s1_nxt.mul_a  = col_flip;
        s1_nxt.mul_b  = view.side_h;
        s1_nxt.offset = row_r;
      end
    endcase
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (view.restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (load) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_r + CNT_W'(1);
      end else begin
        col_nxt = col_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    if (load) begin
      s1_valid_nxt = 1'b1;
    end else if (take) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1       = s1_r;

endmodule

/* rtl/frag_mac.sv */
`timescale 1ns / 1ps
// Multiply-add of the stage-one operands into the result register that
// drives the output channel. Depends on frag_pkg.
module frag_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        s1_valid,
  input  frag_pkg::s1_t               s1,
  input  logic                        out_ready,
  output logic                        take,
  output logic                        out_valid,
  output logic [frag_pkg::ADDR_W-1:0] out_addr,
  output logic [frag_pkg::PIX_W-1:0]  out_pixel,
  output logic                        out_end
);
  import frag_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [PIX_W-1:0]  pixel_r;
  logic              end_r;
  logic [PROD_W-1:0] product;

  assign take = s1_valid && (!out_valid_r || out_ready);

  always_comb begin
    product  = PROD_W'(s1.mul_a) * PROD_W'(s1.mul_b) + PROD_W'(s1.offset);
    addr_nxt = product[ADDR_W-1:0];
  end

  always_comb begin
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      addr_r  <= addr_nxt;
      pixel_r <= s1.pixel;
      end_r   <= s1.frame_end;
    end
  end

  assign out_valid = out_valid_r;
  assign out_addr  = addr_r;
  assign out_pixel = pixel_r;
  assign out_end   = end_r;

endmodule

/* rtl/frame_rotation_address_generator.sv */
`timescale 1ns / 1ps
// Frame rotation address generator top level: configuration registers,
// counter front end and multiply-add result stage. Depends on frag_pkg.
//
// Pixels of a drawn frame enter on the in_ stream in raster order. For each
// request the out_ stream gives the native frame-store address for the
// configured quarter-turn rotation, the pixel itself and tlast on the final
// pixel of the frame. Every input request yields exactly one output request.
// The counters and operand selection fill a stage register, then one
// multiply-add fills the output register. One pixel is taken every
// cycle while the output is drained.
// The cfg_ channel writes rotation (index 0), frame width (1) and frame
// height (2); cfg_ready is always high. A dimension write restarts the frame
// at column and row zero. Configuration is to be written while no pixel is
// in flight.
// Reset empties the pipeline, clears the counters and sets rotation 1 with a
// 480 by 320 frame. When the receiver stalls, up to two pixels are held and
// in_tready falls once both stages are full.
module frame_rotation_address_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [15:0] pixel_in
  input  logic [frag_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [17:0] store_address, [33:18] pixel_out, rest zero
  output logic [frag_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [frag_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [frag_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import frag_pkg::*;

  cfg_view_t         view;
  s1_t               s1;
  logic              s1_valid;
  logic              take;
  logic              load;
  logic [ADDR_W-1:0] out_addr;
  logic [PIX_W-1:0]  out_pixel;

  assign cfg_ready = 1'b1;
  assign in_tready = !s1_valid || take;
  assign load      = in_tvalid && in_tready;

  frag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  frag_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .view     (view),
    .load     (load),
    .take     (take),
    .pixel_in (in_tdata[PIX_W-1:0]),
    .s1_valid (s1_valid),
    .s1       (s1)
  );

  frag_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .out_ready (out_tready),
    .take      (take),
    .out_valid (out_tvalid),
    .out_addr  (out_addr),
    .out_pixel (out_pixel),
    .out_end   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'({out_pixel, out_addr});

  a_ready_only_on_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_valid && out_tvalid && !out_tready))
    else $error("in_tready low while the pipeline can advance");

  a_stage_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid && !out_tvalid) |=> out_tvalid)
    else $error("stage-one pixel not moved into an empty output register");

  a_take_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> s1_valid)
    else $error("output stage loaded without a stage-one pixel");

endmodule
